FILE: hw/rtl/sro_pkg.sv
// shared constants, codes and state types for the segment/rectangle overlap test
`timescale 1ns / 1ps

package sro_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int MAX_PASSES_DEF  = 4;

    // endpoint outcodes
    typedef logic [3:0] t_oc;
    localparam t_oc OC_INSIDE = 4'd0;
    localparam t_oc OC_LEFT   = 4'd1;
    localparam t_oc OC_RIGHT  = 4'd2;
    localparam t_oc OC_BOTTOM = 4'd4;
    localparam t_oc OC_TOP    = 4'd8;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx REG_X_MIN = 2'd0;
    localparam t_cfg_idx REG_Y_MIN = 2'd1;
    localparam t_cfg_idx REG_X_MAX = 2'd2;
    localparam t_cfg_idx REG_Y_MAX = 2'd3;

    // clip sequencer
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_SETUP  = 6'b000100,
        S_WAIT   = 6'b001000,
        S_UPDATE = 6'b010000,
        S_HOLD   = 6'b100000
    } t_seq_state;

    // multiply/divide sequencer
    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_MUL  = 5'b00010,
        M_CHK  = 5'b00100,
        M_DIV  = 5'b01000,
        M_DONE = 5'b10000
    } t_md_state;

endpackage

FILE: hw/rtl/segment_rect_overlap_test.sv
// top level: cohen-sutherland segment vs clip rectangle overlap test
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+-------------------------------------
//   in      | in        | i_in_valid / o_in_ready     | i_start_x i_start_y i_end_x i_end_y
//   out     | out       | o_out_valid / i_out_ready   | o_touches_rect
//   cfg     | in        | i_cfg_we (no wait)          | i_cfg_idx i_cfg_data
//
// an item runs P clip passes, P from 0 to MAX_PASSES; each pass is dominated
// by the shift-add multiply and restoring divide on the shared add/sub unit,
// one bit per cycle.
// reset is synchronous and active low; it clears the rectangle to zero.
// one item at a time; the next beat is taken while a result still waits in the
// output register, and a stalled output holds the sequencer only at its end.
`timescale 1ns / 1ps

module segment_rect_overlap_test #(
    parameter int COORD_WIDTH = sro_pkg::COORD_WIDTH_DEF,
    parameter int MAX_PASSES  = sro_pkg::MAX_PASSES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  sro_pkg::t_cfg_idx             i_cfg_idx,
    input  logic signed [COORD_WIDTH-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_touches_rect
);
    import sro_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int RW = COORD_WIDTH + 3;
    localparam int PW = $clog2(MAX_PASSES + 1);

    t_seq_state            r_state, n_state;
    logic signed [W-1:0]   r_x_min, r_y_min, r_x_max, r_y_max;
    logic signed [W-1:0]   r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    logic [PW-1:0]         r_pass, n_pass;
    logic                  r_sel_start, n_sel_start;
    logic                  r_vert, n_vert;
    logic signed [W-1:0]   r_bound, n_bound;
    logic signed [W-1:0]   r_base, n_base;
    logic                  r_neg, n_neg;
    logic signed [W:0]     r_delta, n_delta, r_num, n_num, r_den, n_den;
    logic                  r_md_start, n_md_start;
    logic                  r_result, n_result;
    logic                  r_out_valid, n_out_valid;
    logic                  r_touches, n_touches;

    t_oc                   c0, c1, co;
    logic                  co_vert;
    logic                  out_free;
    logic                  md_done;
    logic [W+1:0]          md_quot;
    logic [RW-1:0]         base_ext, q_ext, res;
    logic                  res_fits;
    logic signed [W-1:0]   res_sat;

    function automatic t_oc outcode(
        input logic signed [COORD_WIDTH-1:0] x,
        input logic signed [COORD_WIDTH-1:0] y,
        input logic signed [COORD_WIDTH-1:0] xmin,
        input logic signed [COORD_WIDTH-1:0] ymin,
        input logic signed [COORD_WIDTH-1:0] xmax,
        input logic signed [COORD_WIDTH-1:0] ymax
    );
        t_oc c;
        c = OC_INSIDE;
        if (x < xmin) begin
            c = c | OC_LEFT;
        end else if (x > xmax) begin
            c = c | OC_RIGHT;
        end
        if (y < ymin) begin
            c = c | OC_BOTTOM;
        end else if (y > ymax) begin
            c = c | OC_TOP;
        end
        outcode = c;
    endfunction

    sro_muldiv #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_md_start),
        .i_a     (r_delta),
        .i_b     (r_num),
        .i_d     (r_den),
        .o_done  (md_done),
        .o_quot  (md_quot)
    );

    assign c0       = outcode(r_x0, r_y0, r_x_min, r_y_min, r_x_max, r_y_max);
    assign c1       = outcode(r_x1, r_y1, r_x_min, r_y_min, r_x_max, r_y_max);
    assign co       = (c0 != OC_INSIDE) ? c0 : c1;
    assign co_vert  = |(co & (OC_TOP | OC_BOTTOM));
    assign out_free = !r_out_valid || i_out_ready;

    // base +/- quotient, saturated to the coordinate range
    assign base_ext = {{3{r_base[W-1]}}, r_base};
    assign q_ext    = {1'b0, md_quot};
    assign res      = r_neg ? (base_ext - q_ext) : (base_ext + q_ext);
    assign res_fits = (&res[RW-1:W-1]) | ~(|res[RW-1:W-1]);
    assign res_sat  = res_fits ? res[W-1:0]
                    : (res[RW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

    always_comb begin
        n_state     = r_state;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_pass      = r_pass;
        n_sel_start = r_sel_start;
        n_vert      = r_vert;
        n_bound     = r_bound;
        n_base      = r_base;
        n_neg       = r_neg;
        n_delta     = r_delta;
        n_num       = r_num;
        n_den       = r_den;
        n_md_start  = 1'b0;
        n_result    = r_result;
        n_out_valid = r_out_valid && !i_out_ready;
        n_touches   = r_touches;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x0    = i_start_x;
                    n_y0    = i_start_y;
                    n_x1    = i_end_x;
                    n_y1    = i_end_y;
                    n_pass  = '0;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if ((c0 | c1) == OC_INSIDE) begin
                    n_result = 1'b1;
                    n_state  = S_HOLD;
                end else if ((c0 & c1) != OC_INSIDE) begin
                    n_result = 1'b0;
                    n_state  = S_HOLD;
                end else if (r_pass >= PW'(MAX_PASSES)) begin
                    n_result = 1'b0;
                    n_state  = S_HOLD;
                end else if (co_vert ? (r_y1 == r_y0) : (r_x1 == r_x0)) begin
                    // flat segment toward the crossed edge, which would give a zero divisor
                    n_result = 1'b0;
                    n_state  = S_HOLD;
                end else begin
                    n_sel_start = (c0 != OC_INSIDE);
                    n_vert      = co_vert;
                    if (co_vert) begin
                        n_bound = |(co & OC_TOP) ? r_y_max : r_y_min;
                    end else begin
                        n_bound = |(co & OC_RIGHT) ? r_x_max : r_x_min;
                    end
                    n_state = S_SETUP;
                end
                // a decided result goes straight out when the output register is free
                if (n_state == S_HOLD && out_free) begin
                    n_out_valid = 1'b1;
                    n_touches   = n_result;
                    n_state     = S_IDLE;
                end
            end
            S_SETUP: begin
                if (r_vert) begin
                    n_base  = r_x0;
                    n_delta = {r_x1[W-1], r_x1} - {r_x0[W-1], r_x0};
                    n_num   = {r_bound[W-1], r_bound} - {r_y0[W-1], r_y0};
                    n_den   = {r_y1[W-1], r_y1} - {r_y0[W-1], r_y0};
                end else begin
                    n_base  = r_y0;
                    n_delta = {r_y1[W-1], r_y1} - {r_y0[W-1], r_y0};
                    n_num   = {r_bound[W-1], r_bound} - {r_x0[W-1], r_x0};
                    n_den   = {r_x1[W-1], r_x1} - {r_x0[W-1], r_x0};
                end
                n_neg      = n_delta[W] ^ n_num[W] ^ n_den[W];
                n_md_start = 1'b1;
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                if (md_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_sel_start) begin
                    n_x0 = r_vert ? res_sat : r_bound;
                    n_y0 = r_vert ? r_bound : res_sat;
                end else begin
                    n_x1 = r_vert ? res_sat : r_bound;
                    n_y1 = r_vert ? r_bound : res_sat;
                end
                n_pass  = r_pass + 1'b1;
                n_state = S_DECIDE;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_touches   = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_md_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_md_start  <= n_md_start;
            r_out_valid <= n_out_valid;
        end
        r_x0        <= n_x0;
        r_y0        <= n_y0;
        r_x1        <= n_x1;
        r_y1        <= n_y1;
        r_pass      <= n_pass;
        r_sel_start <= n_sel_start;
        r_vert      <= n_vert;
        r_bound     <= n_bound;
        r_base      <= n_base;
        r_neg       <= n_neg;
        r_delta     <= n_delta;
        r_num       <= n_num;
        r_den       <= n_den;
        r_result    <= n_result;
        r_touches   <= n_touches;
    end

    // clip rectangle registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= '0;
            r_y_min <= '0;
            r_x_max <= '0;
            r_y_max <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_X_MIN: r_x_min <= i_cfg_data;
                REG_Y_MIN: r_y_min <= i_cfg_data;
                REG_X_MAX: r_x_max <= i_cfg_data;
                REG_Y_MAX: r_y_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_touches_rect = r_touches;

endmodule

FILE: hw/rtl/sro_addsub.sv
// shared adder/subtractor with carry out, used by the multiply/divide sequencer
`timescale 1ns / 1ps

module sro_addsub #(
    parameter int WIDTH = 34
) (
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic             i_sub,
    output logic [WIDTH:0]   o_sum
);
    import sro_pkg::*;

    logic [WIDTH-1:0] y_op;

    // subtract as x + ~y + 1; carry out high means x >= y
    assign y_op  = i_sub ? ~i_y : i_y;
    assign o_sum = {1'b0, i_x} + {1'b0, y_op} + {{WIDTH{1'b0}}, i_sub};

endmodule

FILE: hw/rtl/sro_muldiv.sv
// iterative |a*b| / |d| with quotient capped at 2^(COORD_WIDTH+1), one add/sub per cycle
`timescale 1ns / 1ps

module sro_muldiv #(
    parameter int COORD_WIDTH = sro_pkg::COORD_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [COORD_WIDTH:0]  i_a,
    input  logic signed [COORD_WIDTH:0]  i_b,
    input  logic signed [COORD_WIDTH:0]  i_d,
    output logic                         o_done,
    output logic [COORD_WIDTH+1:0]       o_quot
);
    import sro_pkg::*;

    localparam int MW = COORD_WIDTH + 1;     // magnitude width
    localparam int AW = COORD_WIDTH + 2;     // adder width, also quotient width
    localparam int CW = $clog2(AW);
    localparam logic [AW-1:0] CAP = {1'b1, {MW{1'b0}}};

    t_md_state       r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [MW-1:0]   r_a, n_a;
    logic [MW-1:0]   r_d, n_d;
    logic [MW-1:0]   r_hi, n_hi;
    logic [MW-1:0]   r_lo, n_lo;
    logic [MW-1:0]   r_rem, n_rem;
    logic [AW-1:0]   r_quo, n_quo;
    logic            r_ovf, n_ovf;

    logic [AW-1:0]   alu_x, alu_y;
    logic            alu_sub;
    logic [AW:0]     alu_sum;
    logic [AW-1:0]   div_t;
    logic            q_big;

    function automatic logic [COORD_WIDTH:0] mag(input logic signed [COORD_WIDTH:0] v);
        mag = v[COORD_WIDTH] ? (~v + 1'b1) : v;
    endfunction

    sro_addsub #(
        .WIDTH (AW)
    ) u_alu (
        .i_x   (alu_x),
        .i_y   (alu_y),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    assign div_t = {r_rem, r_quo[AW-1]};

    // operand steering for the shared unit
    always_comb begin
        alu_x   = {1'b0, r_hi};
        alu_y   = {1'b0, r_a};
        alu_sub = 1'b0;
        unique case (r_state)
            M_MUL: begin
                alu_x   = {1'b0, r_hi};
                alu_y   = {1'b0, r_a};
                alu_sub = 1'b0;
            end
            M_CHK: begin
                // high part of the product already at or above d: quotient overflows
                alu_x   = {2'b00, r_hi[MW-1:1]};
                alu_y   = {1'b0, r_d};
                alu_sub = 1'b1;
            end
            M_DIV: begin
                alu_x   = div_t;
                alu_y   = {1'b0, r_d};
                alu_sub = 1'b1;
            end
            default: begin
                alu_x   = {1'b0, r_hi};
                alu_y   = {1'b0, r_a};
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_d     = r_d;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_ovf   = r_ovf;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_a     = mag(i_a);
                    n_lo    = mag(i_b);
                    n_d     = mag(i_d);
                    n_hi    = '0;
                    n_cnt   = '0;
                    n_state = M_MUL;
                end
            end
            M_MUL: begin
                // shift-add, multiplier bits leave r_lo from the bottom
                if (r_lo[0]) begin
                    n_hi = alu_sum[AW-1:1];
                    n_lo = {alu_sum[0], r_lo[MW-1:1]};
                end else begin
                    n_hi = {1'b0, r_hi[MW-1:1]};
                    n_lo = {r_hi[0], r_lo[MW-1:1]};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(MW - 1)) begin
                    n_state = M_CHK;
                end
            end
            M_CHK: begin
                n_ovf   = alu_sum[AW];
                n_rem   = {1'b0, r_hi[MW-1:1]};
                n_quo   = {r_hi[0], r_lo};
                n_cnt   = '0;
                n_state = M_DIV;
            end
            M_DIV: begin
                // restoring step, quotient bits shift into r_quo
                n_rem = alu_sum[AW] ? alu_sum[MW-1:0] : div_t[MW-1:0];
                n_quo = {r_quo[AW-2:0], alu_sum[AW]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(AW - 1)) begin
                    n_state = M_DONE;
                end
            end
            M_DONE: begin
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_a   <= n_a;
        r_d   <= n_d;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_ovf <= n_ovf;
    end

    assign q_big  = r_quo[AW-1] & (|r_quo[AW-2:0]);
    assign o_done = (r_state == M_DONE);
    assign o_quot = (r_ovf | q_big) ? CAP : r_quo;

endmodule

FILE: tb/overlap_checker.sv
// checker: predicts touches_rect for each accepted segment and compares the result beats
`timescale 1ns / 1ps

module overlap_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  sro_pkg::t_cfg_idx i_cfg_idx,
    input  logic signed [31:0] i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic              i_touches_rect,
    output int                o_errors,
    output int                o_pending
);
    import sro_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int MAX_CLIPS = MAX_PASSES_DEF;
    localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam logic [127:0] QUO_CAP = 128'(1) << (CW + 1);

    longint x_lo, y_lo, x_hi, y_hi;
    bit     touch_q[$];
    bit     want_touch;

    function automatic t_oc region_code(longint x, longint y);
        t_oc c;
        c = OC_INSIDE;
        if (x < x_lo) c |= OC_LEFT;
        else if (x > x_hi) c |= OC_RIGHT;
        if (y < y_lo) c |= OC_BOTTOM;
        else if (y > y_hi) c |= OC_TOP;
        return c;
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // base + trunc(delta * num / den), saturated to the coordinate range
    function automatic longint edge_cross(longint base, longint delta, longint num, longint den);
        logic         neg;
        logic [127:0] quo;
        longint       step;
        longint       res;
        neg = ((delta < 0) != (num < 0)) ^ (den < 0);
        quo = ({64'd0, abs64(delta)} * {64'd0, abs64(num)}) / {64'd0, abs64(den)};
        if (quo > QUO_CAP) quo = QUO_CAP;
        step = longint'(quo[63:0]);
        res = neg ? base - step : base + step;
        if (res > COORD_MAX) res = COORD_MAX;
        if (res < COORD_MIN) res = COORD_MIN;
        return res;
    endfunction

    function automatic bit segment_touches(longint x0, longint y0, longint x1, longint y1);
        t_oc    c0, c1, co;
        longint x, y;
        int     pass;
        c0 = region_code(x0, y0);
        c1 = region_code(x1, y1);
        for (pass = 0; pass <= MAX_CLIPS; pass++) begin
            if ((c0 | c1) == OC_INSIDE) return 1'b1;
            if ((c0 & c1) != OC_INSIDE) return 1'b0;
            if (pass == MAX_CLIPS) return 1'b0;
            co = (c0 != OC_INSIDE) ? c0 : c1;
            if ((co & (OC_TOP | OC_BOTTOM)) != OC_INSIDE) begin
                y = ((co & OC_TOP) != OC_INSIDE) ? y_hi : y_lo;
                if (y1 == y0) return 1'b0;
                x = edge_cross(x0, x1 - x0, y - y0, y1 - y0);
            end else begin
                x = ((co & OC_RIGHT) != OC_INSIDE) ? x_hi : x_lo;
                if (x1 == x0) return 1'b0;
                y = edge_cross(y0, y1 - y0, x - x0, x1 - x0);
            end
            if (co == c0) begin
                x0 = x;
                y0 = y;
                c0 = region_code(x0, y0);
            end else begin
                x1 = x;
                y1 = y;
                c1 = region_code(x1, y1);
            end
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            x_lo = 0;
            y_lo = 0;
            x_hi = 0;
            y_hi = 0;
            touch_q.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (touch_q.size() == 0) begin
                    $error("touches_rect beat with nothing outstanding: expected none, actual %0d",
                           i_touches_rect);
                    o_errors++;
                end else begin
                    want_touch = touch_q.pop_front();
                    if (i_touches_rect !== want_touch) begin
                        $error("touches_rect mismatch: expected %0d, actual %0d",
                               want_touch, i_touches_rect);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                touch_q.push_back(segment_touches(i_start_x, i_start_y, i_end_x, i_end_y));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_X_MIN: x_lo = i_cfg_data;
                    REG_Y_MIN: y_lo = i_cfg_data;
                    REG_X_MAX: x_hi = i_cfg_data;
                    REG_Y_MAX: y_hi = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = touch_q.size();
    end

endmodule

FILE: tb/segment_rect_overlap_test_test.sv
// testbench top: drives segments and clip rectangles into the overlap test and gives the verdict
`timescale 1ns / 1ps

module segment_rect_overlap_test_test;
    import sro_pkg::*;

    localparam longint C_MAX = 64'sd2147483647;
    localparam longint C_MIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_SETS  = 8;
    localparam int SEGS_PER_SET = 92;
    localparam int STALL_LONG   = 1500;
    localparam int DRAIN_CYCLES = 300;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    t_cfg_idx          cfg_idx;
    logic signed [31:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic signed [31:0] start_x, start_y, end_x, end_y;
    logic              out_valid;
    logic              out_ready;
    logic              touches_rect;

    int     n_err;
    int     n_pending;
    bit     calm;
    int     hold_reqs;
    longint cyc;
    longint rx_lo, ry_lo, rx_hi, ry_hi;

    segment_rect_overlap_test dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_start_x      (start_x),
        .i_start_y      (start_y),
        .i_end_x        (end_x),
        .i_end_y        (end_y),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_touches_rect (touches_rect)
    );

    overlap_checker overlap_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_start_x      (start_x),
        .i_start_y      (start_y),
        .i_end_x        (end_x),
        .i_end_y        (end_y),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_touches_rect (touches_rect),
        .o_errors       (n_err),
        .o_pending      (n_pending)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint clamp32(longint v);
        if (v > C_MAX) return C_MAX;
        if (v < C_MIN) return C_MIN;
        return v;
    endfunction

    function automatic longint any_coord();
        return longint'(int'($urandom));
    endfunction

    // somewhere within one rectangle size of [lo, hi] on either side
    function automatic longint near_coord(longint lo, longint hi);
        longint a, b, span;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        span = b - a + 64;
        return clamp32(a - span + longint'({$urandom, $urandom} % 64'(3 * span + 1)));
    endfunction

    function automatic longint edge_or_near(longint lo, longint hi);
        case ($urandom_range(2))
            0: return lo;
            1: return hi;
            default: return near_coord(lo, hi);
        endcase
    endfunction

    function automatic longint half_size();
        return longint'($urandom_range(1 << $urandom_range(30, 0), 0));
    endfunction

    task automatic set_rect(longint xl, longint yl, longint xh, longint yh);
        rx_lo = xl;
        ry_lo = yl;
        rx_hi = xh;
        ry_hi = yh;
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_X_MIN;
        cfg_data <= 32'(xl);
        @(negedge clk);
        cfg_idx  <= REG_Y_MIN;
        cfg_data <= 32'(yl);
        @(negedge clk);
        cfg_idx  <= REG_X_MAX;
        cfg_data <= 32'(xh);
        @(negedge clk);
        cfg_idx  <= REG_Y_MAX;
        cfg_data <= 32'(yh);
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_seg(longint x0, longint y0, longint x1, longint y1);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        start_x  <= 32'(x0);
        start_y  <= 32'(y0);
        end_x    <= 32'(x1);
        end_y    <= 32'(y1);
        do @(posedge clk); while (!in_ready);
    endtask

    // drop valid, then let every outstanding result come back
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (n_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic random_rect(int set);
        longint cx, cy, hx, hy, span;
        cx = $urandom_range(1) ? any_coord() : longint'($urandom_range(2000)) - 1000;
        cy = $urandom_range(1) ? any_coord() : longint'($urandom_range(2000)) - 1000;
        hx = half_size();
        hy = half_size();
        span = half_size();
        case (set)
            0: set_rect(-hx % 5000, -hy % 5000, hx % 5000, hy % 5000);
            1: set_rect(C_MIN, C_MIN, C_MAX, C_MAX);
            // min above max on both axes
            2: set_rect(clamp32(cx + hx + 1), clamp32(cy + hy + 1),
                        clamp32(cx - hx - 1), clamp32(cy - hy - 1));
            3: begin
                if ($urandom_range(1)) set_rect(C_MAX - span, C_MAX - span, C_MAX, C_MAX);
                else set_rect(C_MIN, C_MIN, C_MIN + span, C_MIN + span);
            end
            // zero-width rectangle: a line or a point
            4: set_rect(cx, clamp32(cy - hy), cx, $urandom_range(1) ? clamp32(cy + hy) : clamp32(cy - hy));
            default: set_rect(clamp32(cx - hx), clamp32(cy - hy), clamp32(cx + hx), clamp32(cy + hy));
        endcase
    endtask

    task automatic random_segment();
        longint x0, y0, x1, y1;
        int     mode;
        mode = $urandom_range(9);
        if (mode <= 5) begin
            x0 = near_coord(rx_lo, rx_hi);
            y0 = near_coord(ry_lo, ry_hi);
            x1 = near_coord(rx_lo, rx_hi);
            y1 = near_coord(ry_lo, ry_hi);
        end else if (mode <= 7) begin
            x0 = any_coord();
            y0 = any_coord();
            x1 = any_coord();
            y1 = any_coord();
        end else if (mode == 8) begin
            x0 = near_coord(rx_lo, rx_hi);
            y0 = near_coord(ry_lo, ry_hi);
            x1 = $urandom_range(1) ? x0 : near_coord(rx_lo, rx_hi);
            y1 = (x1 != x0) ? y0 : near_coord(ry_lo, ry_hi);
        end else begin
            x0 = edge_or_near(rx_lo, rx_hi);
            y0 = edge_or_near(ry_lo, ry_hi);
            x1 = edge_or_near(rx_lo, rx_hi);
            y1 = edge_or_near(ry_lo, ry_hi);
        end
        send_seg(x0, y0, x1, y1);
    endtask

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = STALL_LONG;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99) >= 7);
            end
        end
    end

    initial begin
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge clk);
            cyc++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int set;
        int k;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = REG_X_MIN;
        cfg_data  = '0;
        in_valid  = 1'b0;
        start_x   = '0;
        start_y   = '0;
        end_x     = '0;
        end_y     = '0;
        calm      = 1'b0;
        hold_reqs = 0;
        rx_lo = 0;
        ry_lo = 0;
        rx_hi = 0;
        ry_hi = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // rectangle out of reset is the single point at the origin
        send_seg(0, 0, 0, 0);
        send_seg(-5, 3, 5, -3);
        send_seg(-5, 1, 5, 2);
        drain_block();

        set_rect(-1000, -1000, 1000, 1000);
        send_seg(-10, 20, 30, -40);
        send_seg(-5000, -5000, -2000, 300);
        send_seg(-5000, 0, 5000, 0);
        send_seg(1000, 5000, 1000, -5000);
        send_seg(1001, 5000, 1001, -5000);
        send_seg(-3000, 0, 0, 3000);
        send_seg(-3000, -1000, 1000, 3000);
        send_seg(-1500, -1200, 1200, 1500);
        send_seg(0, 0, 9000, 7000);
        send_seg(C_MIN, C_MIN, C_MAX, C_MAX);
        send_seg(C_MIN, C_MAX, C_MAX, C_MIN);
        send_seg(C_MAX, C_MAX, C_MAX, C_MAX);
        drain_block();

        set_rect(C_MIN, C_MIN, C_MAX, C_MAX);
        send_seg(C_MAX, C_MIN, C_MIN, C_MAX);
        drain_block();

        // inverted rectangle: flat segments and saturated crossings
        set_rect(100, 100, -100, -100);
        send_seg(0, 0, 0, 0);
        send_seg(-500, 0, 500, 0);
        send_seg(C_MIN, C_MAX, C_MAX, C_MIN);
        send_seg(-50, C_MIN, 50, C_MAX);

        for (set = 0; set < RANDOM_SETS; set++) begin
            drain_block();
            random_rect(set);
            calm = (set == 5);
            if (set == 6) hold_reqs++;
            for (k = 0; k < SEGS_PER_SET; k++) random_segment();
        end
        calm = 1'b0;

        drain_block();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
